// ----- design/complex_arith_unit_top_macros.svh -----
// assertion macros shared by the checker of the complex arithmetic unit
`ifndef COMPLEX_ARITH_UNIT_TOP_MACROS_SVH
`define COMPLEX_ARITH_UNIT_TOP_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define CAU_ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("complex arith unit: check failed");

// same-cycle implication
`define CAU_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("complex arith unit: check failed");

// next-cycle implication
`define CAU_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("complex arith unit: check failed");

`endif

// ----- design/cau_pkg.sv -----
// types, constants and shared helpers of the complex arithmetic unit
`default_nettype none

package cau_pkg;

    typedef enum logic [2:0] {
        CMD_ADD  = 3'd0,
        CMD_MUL  = 3'd1,
        CMD_DIV  = 3'd2,
        CMD_MOD  = 3'd3,
        CMD_ARG  = 3'd4,
        CMD_CONJ = 3'd5
    } cau_cmd_t;

    localparam int QUOT_BITS    = 17;
    localparam int DIV_NUM_W    = 41;
    localparam int DIV_DEN_W    = 33;
    localparam int DIV_REM_W    = DIV_DEN_W + QUOT_BITS;
    localparam int SQRT_STEPS   = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int UNIT_STAGES  = 18;

    localparam logic signed [15:0] HALF_PI_Q8 = 16'sd402;

    // atan(2^-i) in Q16
    localparam logic signed [17:0] CAU_ATAN [CORDIC_STEPS] = '{
        18'sd51472, 18'sd30386, 18'sd16055, 18'sd8150, 18'sd4091, 18'sd2047,
        18'sd1024, 18'sd512, 18'sd256, 18'sd128, 18'sd64, 18'sd32,
        18'sd16, 18'sd8, 18'sd4, 18'sd2
    };

    typedef struct packed {
        logic [2:0]        command;
        logic signed [15:0] a_real;
        logic signed [15:0] a_imag;
        logic signed [15:0] b_real;
        logic signed [15:0] b_imag;
    } cau_in_t;

    typedef struct packed {
        logic signed [15:0] result_real;
        logic signed [15:0] result_imag;
        logic               saturated;
        logic               divide_by_zero;
    } cau_out_t;

    typedef struct packed {
        logic signed [15:0] val;
        logic               sat;
    } cau_lane_t;

    typedef struct packed {
        logic      valid;
        logic [2:0] cmd;
        cau_lane_t pre_real;
        cau_lane_t pre_imag;
        logic      dz;
        logic      neg_re;
        logic      neg_im;
    } cau_side_t;

    typedef struct packed {
        logic [DIV_NUM_W-1:0] n_re;
        logic [DIV_NUM_W-1:0] n_im;
        logic [DIV_DEN_W-1:0] d;
    } cau_div_in_t;

    typedef struct packed {
        logic [QUOT_BITS-1:0] q_re;
        logic                 ovf_re;
        logic [QUOT_BITS-1:0] q_im;
        logic                 ovf_im;
    } cau_div_out_t;

    // apply sign to a rounded magnitude and clamp to 16 bits
    function automatic cau_lane_t sat_lane(input logic [24:0] q, input logic neg);
        cau_lane_t r;
        r.sat = 1'b0;
        if (neg) begin
            if (q > 25'd32768) begin
                r.val = -16'sd32768;
                r.sat = 1'b1;
            end else begin
                r.val = 16'(16'd0 - q[15:0]);
            end
        end else begin
            if (q > 25'd32767) begin
                r.val = 16'sd32767;
                r.sat = 1'b1;
            end else begin
                r.val = q[15:0];
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/cau_front.sv -----
// input register, products, sums, magnitudes and operand preparation
`default_nettype none

module cau_front (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    en,
    input  wire                    in_valid,
    input  cau_pkg::cau_in_t       in_data,
    output cau_pkg::cau_side_t     side_out,
    output cau_pkg::cau_div_in_t   div_out,
    output logic [31:0]            sq_out,
    output logic signed [15:0]     ar_out,
    output logic signed [15:0]     ai_out
);

    // stage 0
    logic              s0_valid_reg;
    logic [2:0]        s0_cmd_reg;
    logic signed [15:0] s0_ar_reg, s0_ai_reg, s0_br_reg, s0_bi_reg;
    // stage 1
    logic              s1_valid_reg;
    logic [2:0]        s1_cmd_reg;
    logic signed [15:0] s1_ar_reg, s1_ai_reg, s1_br_reg, s1_bi_reg;
    logic signed [31:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [31:0] sq_ar_reg, sq_ai_reg, sq_br_reg, sq_bi_reg;
    // stage 2
    logic              s2_valid_reg;
    logic [2:0]        s2_cmd_reg;
    logic signed [15:0] s2_ar_reg, s2_ai_reg;
    logic signed [32:0] mul_re_reg, mul_im_reg, dnr_reg, dni_reg;
    logic [31:0]       den2_reg, mods2_reg;
    cau_pkg::cau_lane_t pre_re2_reg, pre_im2_reg;
    cau_pkg::cau_lane_t pre_re2_next, pre_im2_next;
    // stage 3
    logic              s3_valid_reg;
    logic [2:0]        s3_cmd_reg;
    logic signed [15:0] s3_ar_reg, s3_ai_reg;
    logic [31:0]       mre_mag_reg, mim_mag_reg, dnr_mag_reg, dni_mag_reg;
    logic              mre_neg_reg, mim_neg_reg, dnr_neg_reg, dni_neg_reg;
    logic [31:0]       den3_reg, mods3_reg;
    cau_pkg::cau_lane_t pre_re3_reg, pre_im3_reg;
    // stage 4
    cau_pkg::cau_side_t   side_reg, side_next;
    cau_pkg::cau_div_in_t div_reg;
    logic [31:0]          sq_reg;
    logic signed [15:0]   ar4_reg, ai4_reg;
    logic [32:0]          mre_rnd, mim_rnd;

    function automatic cau_pkg::cau_lane_t clamp17(input logic signed [16:0] v);
        cau_pkg::cau_lane_t r;
        r.sat = 1'b0;
        r.val = v[15:0];
        if (v > 17'sd32767) begin
            r.val = 16'sd32767;
            r.sat = 1'b1;
        end else if (v < -17'sd32768) begin
            r.val = -16'sd32768;
            r.sat = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [31:0] mag33(input logic signed [32:0] v);
        logic [32:0] t;
        t = v[32] ? 33'(-v) : v;
        return t[31:0];
    endfunction

    always_comb begin
        pre_re2_next = '0;
        pre_im2_next = '0;
        unique case (cau_pkg::cau_cmd_t'(s1_cmd_reg))
            cau_pkg::CMD_ADD: begin
                pre_re2_next = clamp17({s1_ar_reg[15], s1_ar_reg} + {s1_br_reg[15], s1_br_reg});
                pre_im2_next = clamp17({s1_ai_reg[15], s1_ai_reg} + {s1_bi_reg[15], s1_bi_reg});
            end
            cau_pkg::CMD_CONJ: begin
                pre_re2_next.val = s1_ar_reg;
                pre_im2_next = clamp17(17'sd0 - {s1_ai_reg[15], s1_ai_reg});
            end
            default: begin
                pre_re2_next = '0;
                pre_im2_next = '0;
            end
        endcase
    end

    // round to nearest, ties away from zero, on the Q16.16 product sums
    assign mre_rnd = {1'b0, mre_mag_reg} + 33'd128;
    assign mim_rnd = {1'b0, mim_mag_reg} + 33'd128;

    always_comb begin
        side_next          = '0;
        side_next.valid    = s3_valid_reg;
        side_next.cmd      = s3_cmd_reg;
        side_next.pre_real = pre_re3_reg;
        side_next.pre_imag = pre_im3_reg;
        side_next.dz       = (den3_reg == 32'd0);
        side_next.neg_re   = dnr_neg_reg;
        side_next.neg_im   = dni_neg_reg;
        if (cau_pkg::cau_cmd_t'(s3_cmd_reg) == cau_pkg::CMD_MUL) begin
            side_next.pre_real = cau_pkg::sat_lane(mre_rnd[32:8], mre_neg_reg);
            side_next.pre_imag = cau_pkg::sat_lane(mim_rnd[32:8], mim_neg_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            side_reg     <= '0;
        end else if (en) begin
            s0_valid_reg <= in_valid;
            s0_cmd_reg   <= in_data.command;
            s0_ar_reg    <= in_data.a_real;
            s0_ai_reg    <= in_data.a_imag;
            s0_br_reg    <= in_data.b_real;
            s0_bi_reg    <= in_data.b_imag;

            s1_valid_reg <= s0_valid_reg;
            s1_cmd_reg   <= s0_cmd_reg;
            s1_ar_reg    <= s0_ar_reg;
            s1_ai_reg    <= s0_ai_reg;
            s1_br_reg    <= s0_br_reg;
            s1_bi_reg    <= s0_bi_reg;
            p_rr_reg     <= s0_ar_reg * s0_br_reg;
            p_ii_reg     <= s0_ai_reg * s0_bi_reg;
            p_ri_reg     <= s0_ar_reg * s0_bi_reg;
            p_ir_reg     <= s0_ai_reg * s0_br_reg;
            sq_ar_reg    <= s0_ar_reg * s0_ar_reg;
            sq_ai_reg    <= s0_ai_reg * s0_ai_reg;
            sq_br_reg    <= s0_br_reg * s0_br_reg;
            sq_bi_reg    <= s0_bi_reg * s0_bi_reg;

            s2_valid_reg <= s1_valid_reg;
            s2_cmd_reg   <= s1_cmd_reg;
            s2_ar_reg    <= s1_ar_reg;
            s2_ai_reg    <= s1_ai_reg;
            mul_re_reg   <= {p_rr_reg[31], p_rr_reg} - {p_ii_reg[31], p_ii_reg};
            mul_im_reg   <= {p_ri_reg[31], p_ri_reg} + {p_ir_reg[31], p_ir_reg};
            dnr_reg      <= {p_rr_reg[31], p_rr_reg} + {p_ii_reg[31], p_ii_reg};
            dni_reg      <= {p_ir_reg[31], p_ir_reg} - {p_ri_reg[31], p_ri_reg};
            den2_reg     <= {1'b0, sq_br_reg[30:0]} + {1'b0, sq_bi_reg[30:0]};
            mods2_reg    <= {1'b0, sq_ar_reg[30:0]} + {1'b0, sq_ai_reg[30:0]};
            pre_re2_reg  <= pre_re2_next;
            pre_im2_reg  <= pre_im2_next;

            s3_valid_reg <= s2_valid_reg;
            s3_cmd_reg   <= s2_cmd_reg;
            s3_ar_reg    <= s2_ar_reg;
            s3_ai_reg    <= s2_ai_reg;
            mre_mag_reg  <= mag33(mul_re_reg);
            mim_mag_reg  <= mag33(mul_im_reg);
            dnr_mag_reg  <= mag33(dnr_reg);
            dni_mag_reg  <= mag33(dni_reg);
            mre_neg_reg  <= mul_re_reg[32];
            mim_neg_reg  <= mul_im_reg[32];
            dnr_neg_reg  <= dnr_reg[32];
            dni_neg_reg  <= dni_reg[32];
            den3_reg     <= den2_reg;
            mods3_reg    <= mods2_reg;
            pre_re3_reg  <= pre_re2_reg;
            pre_im3_reg  <= pre_im2_reg;

            side_reg     <= side_next;
            // divider sees 2|num| + den over 2 den, numerator already scaled by 256
            div_reg.n_re <= {dnr_mag_reg, 9'd0} + {9'd0, den3_reg};
            div_reg.n_im <= {dni_mag_reg, 9'd0} + {9'd0, den3_reg};
            div_reg.d    <= {den3_reg, 1'b0};
            sq_reg       <= mods3_reg;
            ar4_reg      <= s3_ar_reg;
            ai4_reg      <= s3_ai_reg;
        end
    end

    assign side_out = side_reg;
    assign div_out  = div_reg;
    assign sq_out   = sq_reg;
    assign ar_out   = ar4_reg;
    assign ai_out   = ai4_reg;

endmodule

`default_nettype wire

// ----- design/cau_divider.sv -----
// pipelined restoring divider, one quotient bit per stage, two lanes sharing a divisor
`default_nettype none

module cau_divider (
    input  wire                    aclk,
    input  wire                    en,
    input  cau_pkg::cau_div_in_t   div_in,
    output cau_pkg::cau_div_out_t  div_out
);

    localparam int DIV_STAGES = cau_pkg::QUOT_BITS + 1;

    typedef struct packed {
        logic [cau_pkg::DIV_REM_W-1:0] rem_re;
        logic [cau_pkg::DIV_REM_W-1:0] rem_im;
        logic [cau_pkg::QUOT_BITS-1:0] q_re;
        logic [cau_pkg::QUOT_BITS-1:0] q_im;
        logic                          ovf_re;
        logic                          ovf_im;
        logic [cau_pkg::DIV_DEN_W-1:0] d;
    } cau_div_st_t;

    cau_div_st_t st_reg [DIV_STAGES];

    logic [cau_pkg::DIV_REM_W-1:0] limit;
    logic [cau_pkg::DIV_REM_W-1:0] n_re_ext, n_im_ext;

    assign limit    = {div_in.d, {cau_pkg::QUOT_BITS{1'b0}}};
    assign n_re_ext = {{(cau_pkg::DIV_REM_W - cau_pkg::DIV_NUM_W){1'b0}}, div_in.n_re};
    assign n_im_ext = {{(cau_pkg::DIV_REM_W - cau_pkg::DIV_NUM_W){1'b0}}, div_in.n_im};

    // quotient wider than the field means a clamped result anyway
    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0].rem_re <= n_re_ext;
            st_reg[0].rem_im <= n_im_ext;
            st_reg[0].q_re   <= '0;
            st_reg[0].q_im   <= '0;
            st_reg[0].ovf_re <= (n_re_ext >= limit);
            st_reg[0].ovf_im <= (n_im_ext >= limit);
            st_reg[0].d      <= div_in.d;
        end
    end

    for (genvar j = 1; j < DIV_STAGES; j++) begin : g_bit
        localparam int SHIFT = cau_pkg::QUOT_BITS - j;
        logic [cau_pkg::DIV_REM_W-1:0] sub;
        logic                          take_re, take_im;

        assign sub     = {{cau_pkg::QUOT_BITS{1'b0}}, st_reg[j-1].d} << SHIFT;
        assign take_re = st_reg[j-1].rem_re >= sub;
        assign take_im = st_reg[j-1].rem_im >= sub;

        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[j].rem_re <= take_re ? st_reg[j-1].rem_re - sub : st_reg[j-1].rem_re;
                st_reg[j].rem_im <= take_im ? st_reg[j-1].rem_im - sub : st_reg[j-1].rem_im;
                st_reg[j].q_re   <= {st_reg[j-1].q_re[cau_pkg::QUOT_BITS-2:0], take_re};
                st_reg[j].q_im   <= {st_reg[j-1].q_im[cau_pkg::QUOT_BITS-2:0], take_im};
                st_reg[j].ovf_re <= st_reg[j-1].ovf_re;
                st_reg[j].ovf_im <= st_reg[j-1].ovf_im;
                st_reg[j].d      <= st_reg[j-1].d;
            end
        end
    end

    assign div_out.q_re   = st_reg[DIV_STAGES-1].q_re;
    assign div_out.q_im   = st_reg[DIV_STAGES-1].q_im;
    assign div_out.ovf_re = st_reg[DIV_STAGES-1].ovf_re;
    assign div_out.ovf_im = st_reg[DIV_STAGES-1].ovf_im;

endmodule

`default_nettype wire

// ----- design/cau_sqrt.sv -----
// pipelined digit-by-digit square root with round to nearest and clamp
`default_nettype none

module cau_sqrt (
    input  wire                aclk,
    input  wire                en,
    input  wire [31:0]         sum_in,
    output cau_pkg::cau_lane_t root_out
);

    logic [31:0] s_reg [cau_pkg::SQRT_STEPS];
    logic [31:0] r_reg [cau_pkg::SQRT_STEPS];
    logic [15:0] rnd_reg;
    cau_pkg::cau_lane_t out_reg;

    for (genvar k = 0; k < cau_pkg::SQRT_STEPS; k++) begin : g_step
        localparam logic [31:0] BIT = 32'd1 << (30 - 2 * k);
        logic [31:0] s_in, r_in;
        logic [32:0] trial;
        logic        take;

        if (k == 0) begin : g_first
            assign s_in = sum_in;
            assign r_in = '0;
        end else begin : g_rest
            assign s_in = s_reg[k-1];
            assign r_in = r_reg[k-1];
        end

        assign trial = {1'b0, r_in} + {1'b0, BIT};
        assign take  = {1'b0, s_in} >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                s_reg[k] <= take ? s_in - trial[31:0] : s_in;
                r_reg[k] <= take ? (r_in >> 1) + BIT : (r_in >> 1);
            end
        end
    end

    // remainder above the root means the upper neighbour is nearer
    always_ff @(posedge aclk) begin
        if (en) begin
            rnd_reg <= (s_reg[cau_pkg::SQRT_STEPS-1] > r_reg[cau_pkg::SQRT_STEPS-1])
                       ? r_reg[cau_pkg::SQRT_STEPS-1][15:0] + 16'd1
                       : r_reg[cau_pkg::SQRT_STEPS-1][15:0];
            out_reg.sat <= rnd_reg[15];
            out_reg.val <= rnd_reg[15] ? 16'sd32767 : rnd_reg;
        end
    end

    assign root_out = out_reg;

endmodule

`default_nettype wire

// ----- design/cau_cordic.sv -----
// pipelined cordic vectoring for the argument, one rotation per stage
`default_nettype none

module cau_cordic (
    input  wire                aclk,
    input  wire                en,
    input  wire signed [15:0]  ar_in,
    input  wire signed [15:0]  ai_in,
    output logic signed [15:0] arg_out
);

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [17:0] z;
        logic               ai_zero;
        logic               ar_zero;
        logic               ai_pos;
        logic               neg;
    } cau_rot_t;

    cau_rot_t st_reg [cau_pkg::CORDIC_STEPS + 1];
    logic signed [15:0] out_reg;

    logic [16:0] ar_abs, ai_abs;

    assign ar_abs = ar_in[15] ? 17'(17'd0 - {ar_in[15], ar_in}) : {ar_in[15], ar_in};
    assign ai_abs = ai_in[15] ? 17'(17'd0 - {ai_in[15], ai_in}) : {ai_in[15], ai_in};

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0].x       <= {1'b0, ar_abs, 14'd0};
            st_reg[0].y       <= {1'b0, ai_abs, 14'd0};
            st_reg[0].z       <= '0;
            st_reg[0].ai_zero <= (ai_in == 16'sd0);
            st_reg[0].ar_zero <= (ar_in == 16'sd0);
            st_reg[0].ai_pos  <= !ai_in[15];
            st_reg[0].neg     <= ar_in[15] ^ ai_in[15];
        end
    end

    for (genvar i = 0; i < cau_pkg::CORDIC_STEPS; i++) begin : g_rot
        cau_rot_t cur;
        cau_rot_t rot_next;
        assign cur = st_reg[i];

        always_comb begin
            rot_next = cur;
            if (!cur.y[31]) begin
                rot_next.x = cur.x + (cur.y >>> i);
                rot_next.y = cur.y - (cur.x >>> i);
                rot_next.z = cur.z + cau_pkg::CAU_ATAN[i];
            end else begin
                rot_next.x = cur.x - (cur.y >>> i);
                rot_next.y = cur.y + (cur.x >>> i);
                rot_next.z = cur.z - cau_pkg::CAU_ATAN[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[i+1] <= rot_next;
            end
        end
    end

    cau_rot_t           fin;
    logic [17:0]        z_pos;
    logic [17:0]        z_rnd;
    logic signed [15:0] out_next;

    assign fin   = st_reg[cau_pkg::CORDIC_STEPS];
    assign z_pos = fin.z[17] ? 18'd0 : fin.z;
    assign z_rnd = z_pos + 18'd128;

    always_comb begin
        out_next = fin.neg ? 16'(16'd0 - {6'd0, z_rnd[17:8]}) : {6'd0, z_rnd[17:8]};
        if (fin.ai_zero) begin
            out_next = 16'sd0;
        end else if (fin.ar_zero) begin
            out_next = fin.ai_pos ? cau_pkg::HALF_PI_Q8 : -cau_pkg::HALF_PI_Q8;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign arg_out = out_reg;

endmodule

`default_nettype wire

// ----- design/complex_arith_unit_top.sv -----
// an accepted input transfer passes the front stages, the unit stages and the output register to m_valid
// throughput: one transfer per cycle unless the output is stalled; the whole pipeline advances in lock step
// a stalled output register (m_valid high, m_ready low) freezes every stage
// the divider, square root and cordic units are 18 stages each; most stages do one bit or rotation
// reset: synchronous active low aresetn clears every valid bit; payload is not reset, apart from the side registers
`default_nettype none

module complex_arith_unit_top (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    input  cau_pkg::cau_in_t   s_data,
    output logic               m_valid,
    input  wire                m_ready,
    output cau_pkg::cau_out_t  m_data
);

    logic en;

    cau_pkg::cau_side_t    side_front;
    cau_pkg::cau_div_in_t  div_in;
    cau_pkg::cau_div_out_t div_res;
    logic [31:0]           sq_in;
    logic signed [15:0]    ar_in, ai_in;
    cau_pkg::cau_lane_t    root_res;
    logic signed [15:0]    arg_res;

    cau_pkg::cau_side_t side_reg [cau_pkg::UNIT_STAGES];
    cau_pkg::cau_side_t side_last;

    logic              m_valid_reg;
    cau_pkg::cau_out_t m_data_reg, m_data_next;
    cau_pkg::cau_lane_t div_re, div_im;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    cau_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_valid),
        .in_data  (s_data),
        .side_out (side_front),
        .div_out  (div_in),
        .sq_out   (sq_in),
        .ar_out   (ar_in),
        .ai_out   (ai_in)
    );

    cau_divider u_divider (
        .aclk    (aclk),
        .en      (en),
        .div_in  (div_in),
        .div_out (div_res)
    );

    cau_sqrt u_sqrt (
        .aclk     (aclk),
        .en       (en),
        .sum_in   (sq_in),
        .root_out (root_res)
    );

    cau_cordic u_cordic (
        .aclk    (aclk),
        .en      (en),
        .ar_in   (ar_in),
        .ai_in   (ai_in),
        .arg_out (arg_res)
    );

    // side information walks alongside the arithmetic units
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < cau_pkg::UNIT_STAGES; k++) begin
                side_reg[k] <= '0;
            end
        end else if (en) begin
            side_reg[0] <= side_front;
            for (int k = 1; k < cau_pkg::UNIT_STAGES; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign side_last = side_reg[cau_pkg::UNIT_STAGES-1];

    assign div_re = cau_pkg::sat_lane(div_res.ovf_re ? '1 : {8'd0, div_res.q_re},
                                      side_last.neg_re);
    assign div_im = cau_pkg::sat_lane(div_res.ovf_im ? '1 : {8'd0, div_res.q_im},
                                      side_last.neg_im);

    always_comb begin
        m_data_next = '0;
        unique case (cau_pkg::cau_cmd_t'(side_last.cmd))
            cau_pkg::CMD_ADD, cau_pkg::CMD_MUL, cau_pkg::CMD_CONJ: begin
                m_data_next.result_real = side_last.pre_real.val;
                m_data_next.result_imag = side_last.pre_imag.val;
                m_data_next.saturated   = side_last.pre_real.sat | side_last.pre_imag.sat;
            end
            cau_pkg::CMD_DIV: begin
                if (side_last.dz) begin
                    m_data_next.divide_by_zero = 1'b1;
                end else begin
                    m_data_next.result_real = div_re.val;
                    m_data_next.result_imag = div_im.val;
                    m_data_next.saturated   = div_re.sat | div_im.sat;
                end
            end
            cau_pkg::CMD_MOD: begin
                m_data_next.result_real = root_res.val;
                m_data_next.saturated   = root_res.sat;
            end
            cau_pkg::CMD_ARG: begin
                m_data_next.result_real = arg_res;
            end
            default: begin
                m_data_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= side_last.valid;
            m_data_reg  <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ----- design/cau_checker.sv -----
// port-level checks for the complex arithmetic unit, bound to the top level
`default_nettype none
`include "complex_arith_unit_top_macros.svh"

module cau_checker (
    input wire               aclk,
    input wire               aresetn,
    input wire               s_valid,
    input wire               s_ready,
    input cau_pkg::cau_in_t  s_data,
    input wire               m_valid,
    input wire               m_ready,
    input cau_pkg::cau_out_t m_data
);

    // result held while the sink stalls
    `CAU_ASSERT_NEXT(a_m_valid_held, aclk, aresetn, m_valid && !m_ready, m_valid)
    `CAU_ASSERT_NEXT(a_m_data_held, aclk, aresetn, m_valid && !m_ready, $stable(m_data))

    // input side only stalls when the output register is blocked
    `CAU_ASSERT_ALWAYS(a_ready_follows_out, aclk, aresetn, s_ready == (!m_valid || m_ready))

    // a zero divisor gives zero and never a clamp
    `CAU_ASSERT_IMPL(a_dz_zero, aclk, aresetn, m_valid && m_data.divide_by_zero,
                     m_data.result_real == 16'sd0 && m_data.result_imag == 16'sd0
                     && !m_data.saturated)

endmodule

bind complex_arith_unit_top cau_checker u_cau_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

// ----- sim/tb.sv -----
// testbench of the complex arithmetic unit: directed table then random traffic against a predictor
`timescale 1ns / 1ps

module tb;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    cau_pkg::cau_in_t  s_data = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    cau_pkg::cau_out_t m_data;

    localparam int LATENCY = 23;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        cau_pkg::cau_in_t  din;
        logic              known;
        cau_pkg::cau_out_t dout;
    } stim_row_t;

    cau_pkg::cau_out_t results_due[$];
    int         errors = 0;
    longint     cycles = 0;
    bit         hold_off = 1'b0;
    bit         stim_done = 1'b0;
    stim_row_t  rows[$];

    complex_arith_unit_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #5 aclk = ~aclk;

    function automatic longint clamp_q(input longint v, inout logic sat);
        if (v > 32767) begin
            sat = 1'b1;
            return 32767;
        end
        if (v < -32768) begin
            sat = 1'b1;
            return -32768;
        end
        return v;
    endfunction

    // nearest, ties away from zero; d > 0
    function automatic longint div_round(input longint n, input longint d);
        longint mag;
        longint q;
        mag = (n < 0) ? -n : n;
        q = (2 * mag + d) / (2 * d);
        return (n < 0) ? -q : q;
    endfunction

    function automatic longint sqrt_round(input longint s);
        longint r;
        r = 0;
        while ((r + 1) * (r + 1) <= s) r = r + 1;
        if (s - r * r > r) r = r + 1;
        return r;
    endfunction

    function automatic longint angle_q8(input longint ar, input longint ai);
        longint x, y, z, nx, res;
        logic   neg;
        longint tab [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                             256, 128, 64, 32, 16, 8, 4, 2};
        z = 0;
        if (ai == 0) return 0;
        neg = (ar < 0) != (ai < 0);
        if (ar == 0) return (ai > 0) ? 402 : -402;
        x = ((ar < 0) ? -ar : ar) * 16384;
        y = ((ai < 0) ? -ai : ai) * 16384;
        for (int i = 0; i < 16; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + tab[i];
            end else begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - tab[i];
            end
            x = nx;
        end
        if (z < 0) z = 0;
        res = (z + 128) >>> 8;
        return neg ? -res : res;
    endfunction

    function automatic cau_pkg::cau_out_t complex_result(input cau_pkg::cau_in_t d);
        cau_pkg::cau_out_t o;
        longint ar, ai, br, bi, rr, ri, den;
        logic   sat;
        ar = d.a_real;
        ai = d.a_imag;
        br = d.b_real;
        bi = d.b_imag;
        rr = 0;
        ri = 0;
        sat = 1'b0;
        o = '0;
        case (d.command)
            cau_pkg::CMD_ADD: begin
                rr = clamp_q(ar + br, sat);
                ri = clamp_q(ai + bi, sat);
            end
            cau_pkg::CMD_MUL: begin
                rr = clamp_q(div_round(ar * br - ai * bi, 256), sat);
                ri = clamp_q(div_round(ar * bi + br * ai, 256), sat);
            end
            cau_pkg::CMD_DIV: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    o.divide_by_zero = 1'b1;
                end else begin
                    rr = clamp_q(div_round((ar * br + ai * bi) * 256, den), sat);
                    ri = clamp_q(div_round((br * ai - bi * ar) * 256, den), sat);
                end
            end
            cau_pkg::CMD_MOD: rr = clamp_q(sqrt_round(ar * ar + ai * ai), sat);
            cau_pkg::CMD_ARG: rr = angle_q8(ar, ai);
            cau_pkg::CMD_CONJ: begin
                rr = ar;
                ri = clamp_q(-ai, sat);
            end
            default: ;
        endcase
        o.result_real = rr[15:0];
        o.result_imag = ri[15:0];
        o.saturated = sat;
        return o;
    endfunction

    function automatic cau_pkg::cau_in_t mk(input logic [2:0] c, input int ar, input int ai,
                                            input int br, input int bi);
        cau_pkg::cau_in_t d;
        d.command = c;
        d.a_real = ar[15:0];
        d.a_imag = ai[15:0];
        d.b_real = br[15:0];
        d.b_imag = bi[15:0];
        return d;
    endfunction

    function automatic cau_pkg::cau_out_t res(input int rr, input int ri, input logic sat,
                                              input logic dz);
        cau_pkg::cau_out_t o;
        o.result_real = rr[15:0];
        o.result_imag = ri[15:0];
        o.saturated = sat;
        o.divide_by_zero = dz;
        return o;
    endfunction

    task automatic add_row(input cau_pkg::cau_in_t d, input logic known,
                           input cau_pkg::cau_out_t o);
        stim_row_t r;
        r.din = d;
        r.known = known;
        r.dout = o;
        rows.push_back(r);
    endtask

    function automatic int gap_len();
        return ($urandom_range(0, 15) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    endfunction

    function automatic logic [15:0] rand_field();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'(signed'($urandom_range(0, 2048)) - 1024);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send(input cau_pkg::cau_in_t d, input logic known,
                        input cau_pkg::cau_out_t o);
        s_data <= d;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        results_due.push_back(known ? o : complex_result(d));
        @(negedge aclk);
    endtask

    task automatic pause(input int n);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
    endtask

    // sender
    initial begin
        cau_pkg::cau_in_t d;
        add_row(mk(cau_pkg::CMD_ADD, 32767, -32768, 1, -1), 1'b1,
                res(32767, -32768, 1'b1, 1'b0));
        add_row(mk(cau_pkg::CMD_ADD, -32768, 32767, -32768, 32767), 1'b1,
                res(-32768, 32767, 1'b1, 1'b0));
        add_row(mk(cau_pkg::CMD_ADD, 256, -256, 512, 1), 1'b1, res(768, -255, 1'b0, 1'b0));
        add_row(mk(cau_pkg::CMD_MUL, 256, 0, 256, 0), 1'b1, res(256, 0, 1'b0, 1'b0));
        add_row(mk(cau_pkg::CMD_MUL, 32767, 32767, 32767, -32768), 1'b0, '0);
        add_row(mk(cau_pkg::CMD_MUL, -32768, -32768, -32768, -32768), 1'b0, '0);
        add_row(mk(cau_pkg::CMD_MUL, 384, -128, 1, 1), 1'b0, '0);
        add_row(mk(cau_pkg::CMD_DIV, 1000, -7, 0, 0), 1'b1, res(0, 0, 1'b0, 1'b1));
        add_row(mk(cau_pkg::CMD_DIV, 256, 0, 256, 0), 1'b1, res(256, 0, 1'b0, 1'b0));
        add_row(mk(cau_pkg::CMD_DIV, 32767, -32768, 1, 0), 1'b1,
                res(32767, -32768, 1'b1, 1'b0));
        add_row(mk(cau_pkg::CMD_DIV, -32768, 32767, -32768, -32768), 1'b0, '0);
        add_row(mk(cau_pkg::CMD_MOD, 768, 1024, 0, 0), 1'b1, res(1280, 0, 1'b0, 1'b0));
        add_row(mk(cau_pkg::CMD_MOD, -32768, -32768, 0, 0), 1'b1, res(32767, 0, 1'b1, 1'b0));
        add_row(mk(cau_pkg::CMD_MOD, 0, 0, 5, 5), 1'b1, res(0, 0, 1'b0, 1'b0));
        add_row(mk(cau_pkg::CMD_ARG, 0, 0, 0, 0), 1'b1, res(0, 0, 1'b0, 1'b0));
        add_row(mk(cau_pkg::CMD_ARG, -500, 0, 0, 0), 1'b1, res(0, 0, 1'b0, 1'b0));
        add_row(mk(cau_pkg::CMD_ARG, 0, 77, 0, 0), 1'b1, res(402, 0, 1'b0, 1'b0));
        add_row(mk(cau_pkg::CMD_ARG, 0, -32768, 0, 0), 1'b1, res(-402, 0, 1'b0, 1'b0));
        add_row(mk(cau_pkg::CMD_ARG, 256, 256, 0, 0), 1'b0, '0);
        add_row(mk(cau_pkg::CMD_ARG, -32768, 32767, 0, 0), 1'b0, '0);
        add_row(mk(cau_pkg::CMD_CONJ, 1234, -32768, 0, 0), 1'b1,
                res(1234, 32767, 1'b1, 1'b0));
        add_row(mk(cau_pkg::CMD_CONJ, -32768, 32767, 0, 0), 1'b1,
                res(-32768, -32767, 1'b0, 1'b0));
        add_row(mk(3'd6, 100, 100, 100, 100), 1'b1, res(0, 0, 1'b0, 1'b0));
        add_row(mk(3'd7, -1, -1, -1, -1), 1'b1, res(0, 0, 1'b0, 1'b0));

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        foreach (rows[i]) send(rows[i].din, rows[i].known, rows[i].dout);

        // wait for the pipeline to drain before random traffic
        pause(1);
        while (results_due.size() != 0) @(negedge aclk);

        for (int n = 0; n < 1300; n++) begin
            if (n == 300) hold_off = 1'b1;
            if (n == 700) begin
                pause(1);
                while (results_due.size() != 0) @(negedge aclk);
            end
            d.command = ($urandom_range(0, 20) == 0) ? 3'($urandom_range(6, 7))
                                                     : 3'($urandom_range(0, 5));
            d.a_real = rand_field();
            d.a_imag = rand_field();
            d.b_real = rand_field();
            d.b_imag = rand_field();
            send(d, 1'b0, '0);
            if (n % 200 > 150) continue;
            if ($urandom_range(0, 2) == 0) pause(gap_len());
        end
        s_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver, with one long hold-off counted here
    initial begin
        int stall;
        int gap;
        m_ready <= 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                hold_off = 1'b0;
                m_ready <= 1'b0;
                stall = 0;
                while (stall < 200) begin
                    @(negedge aclk);
                    stall++;
                end
            end
            if ($urandom_range(0, 3) == 0) begin
                gap = gap_len();
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
            m_ready <= 1'b1;
        end
    end

    // result check
    always @(posedge aclk) begin
        cau_pkg::cau_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (results_due.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_data);
                errors++;
            end else begin
                want = results_due.pop_front();
                if (m_data.result_real !== want.result_real ||
                    m_data.result_imag !== want.result_imag ||
                    m_data.saturated !== want.saturated ||
                    m_data.divide_by_zero !== want.divide_by_zero) begin
                    $display("%0t: mismatch expected re %0d im %0d sat %b dz %b, got re %0d im %0d sat %b dz %b",
                             $time, want.result_real, want.result_imag, want.saturated,
                             want.divide_by_zero, m_data.result_real, m_data.result_imag,
                             m_data.saturated, m_data.divide_by_zero);
                    errors++;
                end
            end
        end
    end

    // end of run and timeout
    initial begin
        wait (stim_done);
        while (results_due.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        if (errors == 0 && results_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule

// ----- files.f -----
+incdir+design
design/cau_pkg.sv
design/cau_front.sv
design/cau_divider.sv
design/cau_sqrt.sv
design/cau_cordic.sv
design/complex_arith_unit_top.sv
design/cau_checker.sv
sim/tb.sv
